// ===== rtl/core/egb_pkg.sv =====
// ----------------------------------------------------------------------------
// egb_pkg: shared types and constants
// Holds the operand widths and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package egb_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int COEF_BITS    = 32;
    localparam int CNT_BITS     = 5;

    typedef logic [OPERAND_BITS-1:0] t_operand;
    typedef logic [COEF_BITS-1:0]    t_coef;
    typedef logic [CNT_BITS-1:0]     t_count;

    // Last divider iteration index (one quotient bit per operand bit).
    localparam t_count DIV_LAST = t_count'(OPERAND_BITS - 1);

    typedef struct packed {
        logic load;      // capture a new operand pair
        logic div_init;  // prepare a remainder step
        logic div_step;  // one restoring-division iteration
        logic update;    // rotate remainders and coefficients
        logic out_load;  // copy the result into the output register
    } t_egb_cmd;

    typedef struct packed {
        logic b_zero;    // current divisor is zero, the result is ready
        logic div_last;  // this is the final division iteration
    } t_egb_sts;

endpackage

// ===== rtl/core/egb_if.sv =====
// ----------------------------------------------------------------------------
// egb_in_if / egb_out_if: valid-ready channels
// Operand channel and result channel of the extended gcd block.
// ----------------------------------------------------------------------------
interface egb_in_if;
    logic                  valid;
    logic                  ready;
    logic [30:0]           value_a;
    logic [30:0]           value_b;

    modport source (output valid, output value_a, output value_b, input ready);
    modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

interface egb_out_if;
    logic                  valid;
    logic                  ready;
    logic [30:0]           gcd_value;
    logic signed [31:0]    coef_a;
    logic signed [31:0]    coef_b;

    modport source (output valid, output gcd_value, output coef_a, output coef_b,
                    input ready);
    modport sink   (input valid, input gcd_value, input coef_a, input coef_b,
                    output ready);
endinterface

// ===== rtl/core/extended_gcd_bezout.sv =====
// ----------------------------------------------------------------------------
// extended_gcd_bezout: greatest common divisor with Bezout coefficients
// Computes d = gcd(a, b) and x, y with a*x + b*y = d by the iterative
// extended Euclidean algorithm.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                         Notes
//  i_in     in   value_a[30:0], value_b[30:0]    operand pair
//  o_out    out  gcd_value[30:0], coef_a/b[31:0] result, held in a register
//
// Each remainder step runs a zero check, the bit-serial restoring divider
// (one iteration per operand bit) and an update. Reset is synchronous and
// active low and clears only the controller. A new transaction is accepted
// while the previous result still waits; a finished item waits in the
// controller until the output register frees.
// ----------------------------------------------------------------------------
module extended_gcd_bezout #(
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    egb_in_if.sink    i_in,
    egb_out_if.source o_out
);
    import egb_pkg::*;

    t_egb_cmd w_cmd;
    t_egb_sts w_sts;
    t_coef    w_coef_a, w_coef_b;

    // Controller: owns both handshakes and sequences the datapath.
    egb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath: coefficients are kept modulo 2^DATA_WIDTH.
    egb_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_value_a   (i_in.value_a),
        .i_value_b   (i_in.value_b),
        .o_gcd_value (o_out.gcd_value),
        .o_coef_a    (w_coef_a),
        .o_coef_b    (w_coef_b)
    );

    assign o_out.coef_a = $signed(w_coef_a);
    assign o_out.coef_b = $signed(w_coef_b);

endmodule

// ===== rtl/core/egb_datapath.sv =====
// ----------------------------------------------------------------------------
// egb_datapath: remainder and coefficient registers
// Bit-serial restoring divider with the quotient-times-coefficient products
// built in the same loop, plus the result register.
// ----------------------------------------------------------------------------
module egb_datapath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  egb_pkg::t_egb_cmd i_cmd,
    output egb_pkg::t_egb_sts o_sts,
    input  egb_pkg::t_operand i_value_a,
    input  egb_pkg::t_operand i_value_b,
    output egb_pkg::t_operand o_gcd_value,
    output egb_pkg::t_coef    o_coef_a,
    output egb_pkg::t_coef    o_coef_b
);
    import egb_pkg::*;

    typedef logic [DATA_WIDTH-1:0] t_wcoef;

    t_operand r_rem_a, r_rem_b, r_dvd;
    logic [OPERAND_BITS:0] r_part;
    t_count  r_cnt;
    t_wcoef  r_old_s, r_s, r_old_t, r_t, r_acc_s, r_acc_t;
    t_operand r_gcd;
    t_coef   r_cx, r_cy;

    logic [OPERAND_BITS:0] n_shift, n_diff;
    logic                  n_qbit;
    logic [DATA_WIDTH+COEF_BITS-1:0] n_ext_s, n_ext_t;

    always_comb begin
        n_shift = {r_part[OPERAND_BITS-1:0], r_dvd[OPERAND_BITS-1]};
        n_diff  = n_shift - {1'b0, r_rem_b};
        n_qbit  = (n_shift >= {1'b0, r_rem_b});
        n_ext_s = {{COEF_BITS{1'b0}}, r_old_s};
        n_ext_t = {{COEF_BITS{1'b0}}, r_old_t};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem_a <= i_value_a;
            r_rem_b <= i_value_b;
            r_old_s <= t_wcoef'(1);
            r_s     <= '0;
            r_old_t <= '0;
            r_t     <= t_wcoef'(1);
        end
        if (i_cmd.div_init) begin
            r_part  <= '0;
            r_dvd   <= r_rem_a;
            r_cnt   <= '0;
            r_acc_s <= '0;
            r_acc_t <= '0;
        end
        if (i_cmd.div_step) begin
            r_part  <= n_qbit ? n_diff : n_shift;
            r_dvd   <= {r_dvd[OPERAND_BITS-2:0], 1'b0};
            r_cnt   <= r_cnt + t_count'(1);
            // Product q*s grows MSB first alongside the quotient bits.
            r_acc_s <= {r_acc_s[DATA_WIDTH-2:0], 1'b0} + (n_qbit ? r_s : '0);
            r_acc_t <= {r_acc_t[DATA_WIDTH-2:0], 1'b0} + (n_qbit ? r_t : '0);
        end
        if (i_cmd.update) begin
            r_rem_a <= r_rem_b;
            r_rem_b <= r_part[OPERAND_BITS-1:0];
            r_old_s <= r_s;
            r_s     <= r_old_s - r_acc_s;
            r_old_t <= r_t;
            r_t     <= r_old_t - r_acc_t;
        end
        if (i_cmd.out_load) begin
            r_gcd <= r_rem_a;
            r_cx  <= n_ext_s[COEF_BITS-1:0];
            r_cy  <= n_ext_t[COEF_BITS-1:0];
        end
    end

    assign o_sts.b_zero   = (r_rem_b == '0);
    assign o_sts.div_last = (r_cnt == DIV_LAST);
    assign o_gcd_value    = r_gcd;
    assign o_coef_a       = r_cx;
    assign o_coef_b       = r_cy;

endmodule

// ===== rtl/core/egb_ctrl.sv =====
// ----------------------------------------------------------------------------
// egb_ctrl: sequencing state machine
// Steps the datapath through remainder steps and owns both handshakes.
// ----------------------------------------------------------------------------
module egb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output egb_pkg::t_egb_cmd o_cmd,
    input  egb_pkg::t_egb_sts i_sts
);
    import egb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.b_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
